FILE: design/smsr_pkg.sv
// Package for the serpentine matrix shape raster.
// It holds the opcode, segment and register index codes and the controller/datapath bundles.
// It has no dependencies; the controller, the datapath and the top level import it.
package smsr_pkg;

    // Field and bus widths.
    localparam int COLOR_W   = 24;
    localparam int COORD_W   = 16;
    localparam int EXT_W     = 18;   // Signed width that holds x + w, y + h and the like.
    localparam int DIM_W     = 4;    // Width of the row and column registers.
    localparam int IDX_W     = 2 * DIM_W;
    localparam int LED_W     = 6;
    localparam int OP_W      = 2;
    localparam int CFG_W     = 4;
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 32;

    // Pixel writes per command are capped at this count.
    localparam int OUT_LIMIT = 64;
    localparam int CNT_W     = 7;

    // Register reset values.
    localparam logic [CFG_W-1:0] COLS_RESET = 4'd8;
    localparam logic [CFG_W-1:0] ROWS_RESET = 4'd8;

    // Draw opcodes.
    typedef enum logic [OP_W-1:0] {
        OP_PIXEL = 2'd0,
        OP_HLINE = 2'd1,
        OP_VLINE = 2'd2,
        OP_RECT  = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_MATRIX_COLUMNS = 1'b0,
        REG_MATRIX_ROWS    = 1'b1
    } reg_idx_t;

    // Clipped segments that one command is broken into. Each is scanned row by row.
    typedef enum logic [2:0] {
        SEG_NONE,
        SEG_PIXEL,
        SEG_HLINE,
        SEG_VLINE,
        SEG_BOTTOM,
        SEG_LEFT,
        SEG_RIGHT,
        SEG_FILL
    } seg_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LOAD,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;    // Latch the input request.
        logic load;    // Clip the selected segment and set up its scan.
        logic step;    // Produce one pixel and advance the scan.
        logic flush;   // Send the held pixel out as the final write.
        seg_t seg;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  opcode;
        logic fill_nz;
        logic seg_empty;
        logic seg_last;
        logic count_last;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

FILE: design/smsr_ctrl.sv
// Controller of the serpentine matrix shape raster.
// It walks the segments of a command and paces the datapath. It uses smsr_pkg.
module smsr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  smsr_pkg::dp_status_t status,
    output logic                s_tready,
    output smsr_pkg::ctl_cmd_t  cmd
);
    import smsr_pkg::*;

    state_t state_reg, state_next;
    seg_t   seg_reg, seg_next;
    logic   can_step;
    seg_t   seg_after;

    // The segment that follows the current one in drawing order.
    function automatic seg_t next_seg(input seg_t seg, input op_t op, input logic fill);
        seg_t r;
        r = SEG_NONE;
        unique case (seg)
            SEG_HLINE:  r = (op == OP_RECT) ? SEG_BOTTOM : SEG_NONE;
            SEG_BOTTOM: r = SEG_LEFT;
            SEG_LEFT:   r = SEG_RIGHT;
            SEG_RIGHT:  r = fill ? SEG_FILL : SEG_NONE;
            default:    r = SEG_NONE;
        endcase
        return r;
    endfunction

    // The first segment of each opcode.
    function automatic seg_t first_seg(input op_t op);
        seg_t r;
        r = SEG_NONE;
        unique case (op)
            OP_PIXEL: r = SEG_PIXEL;
            OP_HLINE: r = SEG_HLINE;
            OP_VLINE: r = SEG_VLINE;
            OP_RECT:  r = SEG_HLINE;
            default:  r = SEG_NONE;
        endcase
        return r;
    endfunction

    // A new pixel may be made when the held one can move to the output register.
    assign can_step  = !status.pend_valid || status.out_free;
    assign seg_after = next_seg(seg_reg, status.opcode, status.fill_nz);

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seg_reg   <= SEG_NONE;
        end else begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        seg_next   = seg_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_START;
            end
            ST_START: begin
                seg_next   = first_seg(status.opcode);
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.seg_empty) begin
                    seg_next   = seg_after;
                    state_next = (seg_after == SEG_NONE) ? ST_FLUSH : ST_LOAD;
                end else if (can_step) begin
                    if (status.count_last) begin
                        state_next = ST_FLUSH;
                    end else if (status.seg_last) begin
                        seg_next   = seg_after;
                        state_next = (seg_after == SEG_NONE) ? ST_FLUSH : ST_LOAD;
                    end
                end
            end
            ST_FLUSH: begin
                if (!status.pend_valid || status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready  = 1'b0;
        cmd       = '0;
        cmd.seg   = seg_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_START: ;
            ST_LOAD: begin
                cmd.load = 1'b1;
            end
            ST_SCAN: begin
                cmd.step = !status.seg_empty && can_step;
            end
            ST_FLUSH: begin
                cmd.flush = status.pend_valid && status.out_free;
            end
            default: ;
        endcase
    end

endmodule

FILE: design/smsr_datapath.sv
// Datapath of the serpentine matrix shape raster.
// It holds the request, the matrix size registers, the segment clipper, the scan
// counters, the serpentine index math and the output registers. It uses smsr_pkg.
module smsr_datapath #(
    parameter int MAX_COLUMNS = 8,
    parameter int MAX_ROWS    = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  smsr_pkg::reg_idx_t                  cfg_wr_index,
    input  logic [smsr_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic [smsr_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [smsr_pkg::OP_W-1:0]           s_tuser,
    input  smsr_pkg::ctl_cmd_t                  cmd,
    input  logic                                m_tready,
    output smsr_pkg::dp_status_t                status,
    output logic                                m_tvalid,
    output logic [smsr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import smsr_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] cols_cfg_reg, rows_cfg_reg;
    logic [DIM_W-1:0] cols_eff, rows_eff;

    // Latched request.
    op_t                      op_reg;
    logic signed [EXT_W-1:0]  x_reg, y_reg, w_reg, h_reg;
    logic [COLOR_W-1:0]       dc_reg, fc_reg;

    // Segment scan state.
    logic [DIM_W-1:0] lo_c_reg, hi_c_reg, hi_r_reg, col_reg, row_reg;
    logic             empty_reg;
    logic [CNT_W-1:0] count_reg;
    logic             fill_seg_reg;

    // Held pixel and output register.
    logic             pend_valid_reg;
    logic [LED_W-1:0] pend_idx_reg;
    logic [COLOR_W-1:0] pend_color_reg;
    logic             m_valid_reg, m_last_reg;
    logic [LED_W-1:0] m_idx_reg;
    logic [COLOR_W-1:0] m_color_reg;

    // Clipper signals.
    logic signed [EXT_W-1:0] a, b, c, d, lo_c, hi_c, lo_r, hi_r, cols_s, rows_s;
    logic signed [EXT_W-1:0] one_s;
    logic                    seg_empty_new;

    // Scan and index signals.
    logic [DIM_W:0]   col_inc, row_inc;
    logic [IDX_W-1:0] base, led_idx;
    logic             out_free;

    // Size in use: a register value above the maximum acts as the maximum.
    assign cols_eff = (int'(cols_cfg_reg) > MAX_COLUMNS) ? DIM_W'(MAX_COLUMNS) : cols_cfg_reg;
    assign rows_eff = (int'(rows_cfg_reg) > MAX_ROWS)    ? DIM_W'(MAX_ROWS)    : rows_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= COLS_RESET;
            rows_cfg_reg <= ROWS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_MATRIX_COLUMNS: cols_cfg_reg <= cfg_wr_data;
                REG_MATRIX_ROWS:    rows_cfg_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Request latch.
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            op_reg <= op_t'(s_tuser);
            x_reg  <= EXT_W'(signed'(s_tdata[15:0]));
            y_reg  <= EXT_W'(signed'(s_tdata[31:16]));
            w_reg  <= signed'({2'b00, s_tdata[47:32]});
            h_reg  <= signed'({2'b00, s_tdata[63:48]});
            dc_reg <= s_tdata[87:64];
            fc_reg <= s_tdata[111:88];
        end
    end

    // Bounds of each segment as half-open column and row ranges.
    assign one_s = EXT_W'(1);
    always_comb begin
        a = '0;
        b = '0;
        c = '0;
        d = '0;
        unique case (cmd.seg)
            SEG_PIXEL: begin
                a = x_reg;                 b = x_reg + one_s;
                c = y_reg;                 d = y_reg + one_s;
            end
            SEG_HLINE: begin
                a = x_reg;                 b = x_reg + w_reg;
                c = y_reg;                 d = y_reg + one_s;
            end
            SEG_VLINE: begin
                a = x_reg;                 b = x_reg + one_s;
                c = y_reg;                 d = y_reg + h_reg;
            end
            SEG_BOTTOM: begin
                a = x_reg;                 b = x_reg + w_reg;
                c = y_reg + h_reg - one_s; d = y_reg + h_reg;
            end
            SEG_LEFT: begin
                a = x_reg;                 b = x_reg + one_s;
                c = y_reg + one_s;         d = y_reg + h_reg - one_s;
            end
            SEG_RIGHT: begin
                a = x_reg + w_reg - one_s; b = x_reg + w_reg;
                c = y_reg + one_s;         d = y_reg + h_reg - one_s;
            end
            SEG_FILL: begin
                a = x_reg + one_s;         b = x_reg + w_reg - one_s;
                c = y_reg + one_s;         d = y_reg + h_reg - one_s;
            end
            default: ;
        endcase
    end

    // Clip to the matrix; anything off the matrix is dropped.
    assign cols_s = signed'({{(EXT_W-DIM_W){1'b0}}, cols_eff});
    assign rows_s = signed'({{(EXT_W-DIM_W){1'b0}}, rows_eff});
    assign lo_c   = (a < 0) ? '0 : a;
    assign hi_c   = (b > cols_s) ? cols_s : b;
    assign lo_r   = (c < 0) ? '0 : c;
    assign hi_r   = (d > rows_s) ? rows_s : d;
    assign seg_empty_new = (lo_c >= hi_c) || (lo_r >= hi_r);

    // Scan counters: columns inner, rows outer.
    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign row_inc = {1'b0, row_reg} + 1'b1;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            empty_reg    <= seg_empty_new;
            lo_c_reg     <= lo_c[DIM_W-1:0];
            hi_c_reg     <= hi_c[DIM_W-1:0];
            hi_r_reg     <= hi_r[DIM_W-1:0];
            col_reg      <= lo_c[DIM_W-1:0];
            row_reg      <= lo_r[DIM_W-1:0];
            fill_seg_reg <= (cmd.seg == SEG_FILL);
        end else if (cmd.step) begin
            if (col_inc == {1'b0, hi_c_reg}) begin
                col_reg <= lo_c_reg;
                row_reg <= row_inc[DIM_W-1:0];
            end else begin
                col_reg <= col_inc[DIM_W-1:0];
            end
        end
    end

    // Serpentine index: even columns run upward, odd columns downward.
    assign base    = {{DIM_W{1'b0}}, col_reg} * {{DIM_W{1'b0}}, rows_eff};
    assign led_idx = base + (col_reg[0] ? {{DIM_W{1'b0}}, row_reg}
                                        : {{DIM_W{1'b0}}, rows_eff - row_reg - 1'b1});

    assign out_free = !m_valid_reg || m_tready;

    // Write counter per request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.take) begin
            count_reg <= '0;
        end else if (cmd.step) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // Valid flags of the held pixel and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.step) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.step && pend_valid_reg) || cmd.flush) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the held pixel and the output register.
    always_ff @(posedge aclk) begin
        if ((cmd.step && pend_valid_reg) || cmd.flush) begin
            m_idx_reg   <= pend_idx_reg;
            m_color_reg <= pend_color_reg;
            m_last_reg  <= cmd.flush;
        end
        if (cmd.step) begin
            pend_idx_reg   <= led_idx[LED_W-1:0];
            pend_color_reg <= fill_seg_reg ? fc_reg : dc_reg;
        end
    end

    // Status to the controller.
    always_comb begin
        status.opcode     = op_reg;
        status.fill_nz    = (fc_reg != '0);
        status.seg_empty  = empty_reg;
        status.seg_last   = (col_inc == {1'b0, hi_c_reg}) && (row_inc == {1'b0, hi_r_reg});
        status.count_last = (count_reg == CNT_W'(OUT_LIMIT - 1));
        status.pend_valid = pend_valid_reg;
        status.out_free   = out_free;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W-LED_W-COLOR_W){1'b0}}, m_color_reg, m_idx_reg};

endmodule

FILE: design/serpentine_matrix_shape_raster.sv
// Top level of the serpentine matrix shape raster.
// It joins the controller smsr_ctrl and the datapath smsr_datapath; both use smsr_pkg.
//
//  Channel   Direction  Carries
//  s_        in         one draw request (opcode in tuser, shape and colors in tdata)
//  m_        out        one pixel write per transfer (LED index and color, tlast on final)
//  cfg_wr_   in         matrix_columns (index 0) and matrix_rows (index 1), write only
//
// A request is taken in the idle state and passes through a start state, then a load state
// that clips each of its segments and a scan state that writes its pixels or skips a segment
// that clips to nothing; a flush state then sends the final pixel. The pixel scan in the
// datapath makes one pixel per cycle while the m_ side does not stall.
// Reset is synchronous and active low; there is no clearing pass.
// A stalled m_ side holds the scan once the held pixel and the output register are full.
module serpentine_matrix_shape_raster #(
    parameter int MAX_COLUMNS = 8,
    parameter int MAX_ROWS    = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  smsr_pkg::reg_idx_t                 cfg_wr_index,
    input  logic [smsr_pkg::CFG_W-1:0]         cfg_wr_data,
    // Draw requests.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // x_pos[15:0], y_pos[31:16], extent_w[47:32], extent_h[63:48],
    // draw_color[87:64], fill_color[111:88]
    input  logic [smsr_pkg::S_TDATA_W-1:0]     s_tdata,
    // opcode[1:0]
    input  logic [smsr_pkg::OP_W-1:0]          s_tuser,
    // Pixel writes.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // led_index[5:0], pixel_color[29:6], zero[31:30]
    output logic [smsr_pkg::M_TDATA_W-1:0]     m_tdata,
    // last_pixel
    output logic                               m_tlast
);
    import smsr_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    smsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    smsr_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .cmd          (cmd),
        .m_tready     (m_tready),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

FILE: design/smsr_checker.sv
// Port checker for the serpentine matrix shape raster.
// It watches the top-level ports only and is bound to serpentine_matrix_shape_raster.
module smsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // A stalled pixel write keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled pixel write changed");

    // No pixel write is offered right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("pixel write valid after reset");

    // While a new request may enter, only the final write of the last request can wait.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("request taken while writes of the previous one remain");

    // One request at a time: after an accepted request the input closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken before the first was expanded");

endmodule

bind serpentine_matrix_shape_raster smsr_checker u_smsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: dv/testbench.sv
// Testbench for serpentine_matrix_shape_raster: draw requests in, pixel writes out.
// It needs smsr_pkg and the RTL top level; a built-in rasterizer predicts the pixel writes of most requests.
`timescale 1ns / 1ps

module testbench;
    import smsr_pkg::*;

    localparam int MAX_COLUMNS  = 8;
    localparam int MAX_ROWS     = 8;
    localparam int N_DIRECTED   = 25;
    localparam int N_PHASES     = 9;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 100;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int REPORT_LIMIT = 30;

    // How a directed row is checked: by the rasterizer, or against a value typed in.
    typedef enum logic [1:0] {
        CHECK_MODEL,
        NO_WRITE,
        ONE_WRITE
    } row_check_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        w;
        logic [15:0]        h;
        logic [23:0]        dc;
        logic [23:0]        fc;
        row_check_t         chk;
        logic [5:0]         led;
    } draw_req_t;

    typedef struct packed {
        logic [5:0]  led;
        logic [23:0] color;
        logic        last;
    } pixel_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    reg_idx_t               cfg_wr_index = REG_MATRIX_COLUMNS;
    logic [CFG_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    // Local copy of the matrix size registers.
    logic [CFG_W-1:0] columns_reg;
    logic [CFG_W-1:0] rows_reg;
    int               cols_in_use;
    int               rows_in_use;

    // Predicted writes of the request being rasterized, then per offered request.
    pixel_t raster_out[$];
    pixel_t pixels_offered[$];
    int     request_sizes[$];
    pixel_t pixels_due[$];

    int  fail_count = 0;
    int  requests_taken = 0;
    int  pixels_seen = 0;
    int  settings_count = 1;
    int  cycle_count = 0;
    bit  steady = 1'b0;
    bit  hold_pending = 1'b0;

    draw_req_t directed_rows[N_DIRECTED];
    logic [CFG_W-1:0] phase_cols[N_PHASES];
    logic [CFG_W-1:0] phase_rows[N_PHASES];

    serpentine_matrix_shape_raster #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        // x_pos[15:0], y_pos[31:16], extent_w[47:32], extent_h[63:48],
        // draw_color[87:64], fill_color[111:88]
        .s_tdata      (s_tdata),
        // opcode[1:0]
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        // led_index[5:0], pixel_color[29:6], zero[31:30]
        .m_tdata      (m_tdata),
        // last_pixel
        .m_tlast      (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // One LED write, dropped when off the matrix or past the per-request cap.
    function automatic void plot(int px, int py, logic [23:0] c);
        int     idx;
        pixel_t p;
        if (px < 0 || py < 0 || px >= cols_in_use || py >= rows_in_use) return;
        if (raster_out.size() >= OUT_LIMIT) return;
        // Even columns run upward along the chain, odd columns downward.
        if (px % 2 == 0)
            idx = px * rows_in_use + (rows_in_use - 1 - py);
        else
            idx = px * rows_in_use + py;
        p.led = idx[5:0];
        p.color = c;
        p.last = 1'b0;
        raster_out.push_back(p);
    endfunction

    function automatic void span_row(int x, int y, int len, logic [23:0] c);
        int lo;
        int hi;
        if (len <= 0 || y < 0 || y >= rows_in_use) return;
        lo = (x < 0) ? 0 : x;
        hi = x + len;
        if (hi > cols_in_use) hi = cols_in_use;
        for (int i = lo; i < hi; i++) plot(i, y, c);
    endfunction

    function automatic void span_column(int x, int y, int len, logic [23:0] c);
        int lo;
        int hi;
        if (len <= 0 || x < 0 || x >= cols_in_use) return;
        lo = (y < 0) ? 0 : y;
        hi = y + len;
        if (hi > rows_in_use) hi = rows_in_use;
        for (int i = lo; i < hi; i++) plot(x, i, c);
    endfunction

    // Expands one draw request into its pixel writes, in drawing order.
    function automatic void rasterize(draw_req_t r);
        int     x;
        int     y;
        int     w;
        int     h;
        int     first_row;
        pixel_t p;
        x = $signed(r.x);
        y = $signed(r.y);
        w = int'(r.w);
        h = int'(r.h);
        cols_in_use = (columns_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(columns_reg);
        rows_in_use = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
        raster_out.delete();
        case (r.op)
            OP_PIXEL: plot(x, y, r.dc);
            OP_HLINE: span_row(x, y, w, r.dc);
            OP_VLINE: span_column(x, y, h, r.dc);
            default: begin
                // Top, bottom, left and right edges, then the interior.
                span_row(x, y, w, r.dc);
                span_row(x, y + h - 1, w, r.dc);
                span_column(x, y + 1, h - 2, r.dc);
                span_column(x + w - 1, y + 1, h - 2, r.dc);
                if (r.fc != 24'd0) begin
                    first_row = (y + 1 < 0) ? 0 : y + 1;
                    for (int row = first_row; row <= y + h - 2 && row < rows_in_use; row++)
                        span_row(x + 1, row, w - 2, r.fc);
                end
            end
        endcase
        if (raster_out.size() > 0) begin
            p = raster_out.pop_back();
            p.last = 1'b1;
            raster_out.push_back(p);
        end
    endfunction

    // Random request: mostly near the matrix, some with full-range fields.
    function automatic draw_req_t pick_request();
        draw_req_t r;
        int        sel;
        sel = $urandom_range(9);
        r.op = (sel < 2) ? OP_PIXEL : (sel < 4) ? OP_HLINE : (sel < 6) ? OP_VLINE : OP_RECT;
        if ($urandom_range(99) < 15) begin
            r.x = 16'($urandom);
            r.y = 16'($urandom);
            r.w = 16'($urandom);
            r.h = 16'($urandom);
        end else begin
            r.x = 16'(int'($urandom_range(12)) - 3);
            r.y = 16'(int'($urandom_range(12)) - 3);
            r.w = 16'($urandom_range(10));
            r.h = 16'($urandom_range(10));
        end
        r.dc = 24'($urandom);
        r.fc = ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom);
        r.chk = CHECK_MODEL;
        r.led = '0;
        return r;
    endfunction

    // Offers one request and returns at the edge where it is taken.
    task automatic offer_request(draw_req_t r);
        pixel_t p;
        if (r.chk == CHECK_MODEL) begin
            rasterize(r);
        end else begin
            raster_out.delete();
            if (r.chk == ONE_WRITE) begin
                p.led = r.led;
                p.color = r.dc;
                p.last = 1'b1;
                raster_out.push_back(p);
            end
        end
        request_sizes.push_back(raster_out.size());
        foreach (raster_out[i]) pixels_offered.push_back(raster_out[i]);
        s_tvalid <= 1'b1;
        s_tuser <= r.op;
        s_tdata <= {r.fc, r.dc, r.h, r.w, r.y, r.x};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Random gap between requests unless the phase runs without idling.
    task automatic sender_pause();
        if (!steady && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    // Waits until every request is taken and every pixel write has come back.
    task automatic settle();
        while (request_sizes.size() != 0 || pixels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_matrix(logic [CFG_W-1:0] c, logic [CFG_W-1:0] r);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= REG_MATRIX_COLUMNS;
        cfg_wr_data <= c;
        @(posedge aclk);
        cfg_wr_index <= REG_MATRIX_ROWS;
        cfg_wr_data <= r;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        columns_reg = c;
        rows_reg = r;
        settings_count++;
    endtask

    // Receiver: random stalls, a no-stall phase, and one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 16);
            end
        end
    end

    // Scoreboard: compare taken pixel writes, then queue those of a newly taken request.
    pixel_t seen_px;
    pixel_t due_px;
    int     taken_n;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                pixels_seen++;
                seen_px.led = m_tdata[5:0];
                seen_px.color = m_tdata[29:6];
                seen_px.last = m_tlast;
                if (pixels_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected pixel write, led %0d color %06h last %0b",
                                 $time, seen_px.led, seen_px.color, seen_px.last);
                end else begin
                    due_px = pixels_due.pop_front();
                    if (seen_px != due_px) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: expected led %0d color %06h last %0b, got %0d %06h %0b",
                                     $time, due_px.led, due_px.color, due_px.last,
                                     seen_px.led, seen_px.color, seen_px.last);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                requests_taken++;
                taken_n = request_sizes.pop_front();
                repeat (taken_n) pixels_due.push_back(pixels_offered.pop_front());
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d writes outstanding.",
                     cycle_count, pixels_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        // Row: op, x, y, w, h, draw color, fill color, check, led (8 x 8 after reset).
        directed_rows = '{
            '{OP_PIXEL, 16'sd0, 16'sd0, 16'd0, 16'd0, 24'hFFFFFF, 24'h0, ONE_WRITE, 6'd7},
            '{OP_PIXEL, 16'sd1, 16'sd0, 16'd0, 16'd0, 24'h000001, 24'h0, ONE_WRITE, 6'd8},
            '{OP_PIXEL, 16'sd7, 16'sd7, 16'd0, 16'd0, 24'hAAAAAA, 24'h555555, ONE_WRITE, 6'd63},
            // Unused extents and fill are ignored by a single pixel.
            '{OP_PIXEL, 16'sd0, 16'sd7, 16'hFFFF, 16'hFFFF, 24'h123456, 24'hFFFFFF,
              ONE_WRITE, 6'd0},
            '{OP_PIXEL, -16'sd1, 16'sd0, 16'd0, 16'd0, 24'h00FF00, 24'h0, NO_WRITE, 6'd0},
            '{OP_PIXEL, 16'sd0, 16'sd8, 16'd0, 16'd0, 24'h00FF00, 24'h0, NO_WRITE, 6'd0},
            '{OP_PIXEL, 16'sh8000, 16'sh7FFF, 16'd0, 16'd0, 24'hFF0000, 24'h0, NO_WRITE, 6'd0},
            '{OP_PIXEL, 16'sh7FFF, 16'sh8000, 16'd0, 16'd0, 24'hFF0000, 24'h0, NO_WRITE, 6'd0},
            '{OP_HLINE, 16'sd0, 16'sd0, 16'd8, 16'd0, 24'h0000FF, 24'h0, CHECK_MODEL, 6'd0},
            '{OP_HLINE, -16'sd3, 16'sd2, 16'd5, 16'd0, 24'h00FFFF, 24'h0, CHECK_MODEL, 6'd0},
            '{OP_HLINE, 16'sd2, 16'sd3, 16'd0, 16'd9, 24'h00FFFF, 24'h0, NO_WRITE, 6'd0},
            '{OP_HLINE, 16'sd0, 16'sd5, 16'hFFFF, 16'd0, 24'hF0F0F0, 24'h0, CHECK_MODEL, 6'd0},
            '{OP_VLINE, 16'sd3, -16'sd2, 16'd0, 16'hFFFF, 24'h0F0F0F, 24'h0, CHECK_MODEL, 6'd0},
            '{OP_VLINE, 16'sd5, 16'sd0, 16'd9, 16'd0, 24'h0F0F0F, 24'h0, NO_WRITE, 6'd0},
            '{OP_VLINE, 16'sd7, 16'sd1, 16'd0, 16'd3, 24'h808080, 24'h0, CHECK_MODEL, 6'd0},
            '{OP_VLINE, 16'sd8, 16'sd0, 16'd0, 16'd8, 24'h808080, 24'h0, NO_WRITE, 6'd0},
            // Full-matrix rectangle with and without fill.
            '{OP_RECT, 16'sd0, 16'sd0, 16'd8, 16'd8, 24'hFF00FF, 24'h00FF00, CHECK_MODEL, 6'd0},
            '{OP_RECT, 16'sd0, 16'sd0, 16'd8, 16'd8, 24'hFF00FF, 24'h0, CHECK_MODEL, 6'd0},
            // One row high, one column wide.
            '{OP_RECT, 16'sd2, 16'sd2, 16'd3, 16'd1, 24'h111111, 24'h222222, CHECK_MODEL, 6'd0},
            '{OP_RECT, 16'sd1, 16'sd1, 16'd1, 16'd4, 24'h333333, 24'h444444, CHECK_MODEL, 6'd0},
            '{OP_RECT, -16'sd2, -16'sd2, 16'd5, 16'd5, 24'h666666, 24'h777777, CHECK_MODEL, 6'd0},
            // Far edges past the 16-bit range must be dropped, not wrapped.
            '{OP_RECT, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 24'h999999, 24'hBBBBBB,
              NO_WRITE, 6'd0},
            // Edges all off the matrix, interior covering all of it.
            '{OP_RECT, 16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF, 24'hCCCCCC, 24'hDDDDDD,
              CHECK_MODEL, 6'd0},
            '{OP_RECT, 16'sd6, 16'sd6, 16'd2, 16'd2, 24'hEEEEEE, 24'h010101, CHECK_MODEL, 6'd0},
            '{OP_RECT, 16'sd0, 16'sd0, 16'd0, 16'd0, 24'hEEEEEE, 24'h010101, NO_WRITE, 6'd0}
        };
        // Matrix sizes per random phase, empty and beyond-maximum among them.
        phase_cols = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd3, 4'd8, 4'd1, 4'd5, 4'd8};
        phase_rows = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd6, 4'd1, 4'd8, 4'd4, 4'd8};
    end

    // Main sequence.
    initial begin
        columns_reg = COLS_RESET;
        rows_reg = ROWS_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            offer_request(directed_rows[k]);
            sender_pause();
        end
        s_tvalid <= 1'b0;
        settle();

        // Reset size with the receiver held off while requests keep coming.
        hold_pending = 1'b1;
        for (int k = 0; k < 40; k++) begin
            offer_request(pick_request());
            sender_pause();
        end
        s_tvalid <= 1'b0;
        settle();

        for (int p = 0; p < N_PHASES; p++) begin
            set_matrix(phase_cols[p], phase_rows[p]);
            steady = (p == 3);
            for (int k = 0; k < 20; k++) begin
                offer_request(pick_request());
                sender_pause();
            end
            s_tvalid <= 1'b0;
            settle();
            steady = 1'b0;
        end

        $display("Covered %0d draw requests over %0d matrix sizes, %0d pixel writes checked.",
                 requests_taken, settings_count, pixels_seen);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches.", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
